// ===== rtl/core/rc6_pkg.sv =====
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared constants, opcodes, control structs and word functions of the
// RC6-32/r/16 block cipher core.
// ----------------------------------------------------------------------------
package rc6_pkg;

    localparam int NUM_ROUNDS_DEF = 20;

    localparam logic [31:0] P32   = 32'hb7e15163;
    localparam logic [31:0] Q32   = 32'h9e3779b9;
    localparam logic [31:0] Q32X2 = Q32 + Q32;

    localparam int LG_W   = 5;
    localparam int KS_ROT = 3;

    localparam logic [1:0] OP_LOAD_KEY = 2'd0;
    localparam logic [1:0] OP_ENCRYPT  = 2'd1;
    localparam logic [1:0] OP_DECRYPT  = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    // write control of the round key memory (one enable per 32-bit lane)
    typedef struct packed {
        logic       en;
        logic [1:0] lane_we;
    } t_wr_ctl;

    // block engine command
    typedef struct packed {
        logic start;
        logic decrypt;
    } t_blk_cmd;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} >> n;
        return w[31:0];
    endfunction

endpackage

// ===== rtl/core/rc6_rkram.sv =====
// ----------------------------------------------------------------------------
// rc6_rkram
// Round key memory: one row per round key pair, two 32-bit lanes with
// separate write enables, one read port with registered data.
// ----------------------------------------------------------------------------
module rc6_rkram
    import rc6_pkg::*;
#(
    parameter int ROWS  = NUM_ROUNDS_DEF + 2,
    parameter int ROW_W = $clog2(ROWS)
) (
    input  logic             i_clk,
    input  t_wr_ctl          i_wr,
    input  logic [ROW_W-1:0] i_wr_row,
    input  logic [63:0]      i_wr_data,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_row,
    output logic [63:0]      o_rd_data
);

    logic [1:0][31:0] mem [ROWS];
    logic [63:0]      r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.lane_we[0]) begin
                mem[i_wr_row][0] <= i_wr_data[31:0];
            end
            if (i_wr.lane_we[1]) begin
                mem[i_wr_row][1] <= i_wr_data[63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/rc6_keysched.sv =====
// ----------------------------------------------------------------------------
// rc6_keysched
// Key schedule sequencer: clears the round key memory after reset, then on
// request fills it with the P/Q series and runs the mixing steps in place.
// ----------------------------------------------------------------------------
module rc6_keysched
    import rc6_pkg::*;
#(
    parameter int ROWS  = NUM_ROUNDS_DEF + 2,
    parameter int ROW_W = $clog2(ROWS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [127:0]     i_key,
    input  logic [63:0]      i_rd_data,
    output logic             o_rd_en,
    output logic [ROW_W-1:0] o_rd_row,
    output t_wr_ctl          o_wr,
    output logic [ROW_W-1:0] o_wr_row,
    output logic [63:0]      o_wr_data,
    output logic             o_clearing,
    output logic             o_done
);

    localparam int MIX_STEPS = 6 * ROWS;
    localparam int CNT_W     = $clog2(MIX_STEPS);

    localparam logic [2:0] KS_CLEAR = 3'd0;
    localparam logic [2:0] KS_IDLE  = 3'd1;
    localparam logic [2:0] KS_INIT  = 3'd2;
    localparam logic [2:0] KS_MIXRD = 3'd3;
    localparam logic [2:0] KS_MIXA  = 3'd4;
    localparam logic [2:0] KS_MIXB  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_lane, n_lane;
    logic [1:0]       r_j, n_j;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_a, n_a;
    logic [31:0]      r_b, n_b;
    logic [31:0]      r_v, n_v;
    logic [3:0][31:0] r_l, n_l;

    logic        row_last;
    logic [31:0] s_word;
    logic [31:0] a_new;
    logic [31:0] ab_sum;
    logic [31:0] b_new;

    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign s_word   = r_lane ? i_rd_data[63:32] : i_rd_data[31:0];
    assign a_new    = rotl32(s_word + r_a + r_b, 5'(KS_ROT));
    assign ab_sum   = r_a + r_b;
    assign b_new    = rotl32(r_l[r_j] + ab_sum, ab_sum[4:0]);

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_lane    = r_lane;
        n_j       = r_j;
        n_cnt     = r_cnt;
        n_a       = r_a;
        n_b       = r_b;
        n_v       = r_v;
        n_l       = r_l;
        o_rd_en   = 1'b0;
        o_rd_row  = r_row;
        o_wr      = '0;
        o_wr_data = '0;
        o_done    = 1'b0;
        unique case (r_state)
            KS_CLEAR: begin
                o_wr.en      = 1'b1;
                o_wr.lane_we = 2'b11;
                n_row        = r_row + 1'b1;
                if (row_last) begin
                    n_row   = '0;
                    n_state = KS_IDLE;
                end
            end
            KS_IDLE: begin
                if (i_start) begin
                    n_l     = i_key;
                    n_v     = P32;
                    n_row   = '0;
                    n_state = KS_INIT;
                end
            end
            KS_INIT: begin
                o_wr.en      = 1'b1;
                o_wr.lane_we = 2'b11;
                o_wr_data    = {r_v + Q32, r_v};
                n_v          = r_v + Q32X2;
                n_row        = r_row + 1'b1;
                if (row_last) begin
                    n_row   = '0;
                    n_lane  = 1'b0;
                    n_j     = '0;
                    n_cnt   = '0;
                    n_a     = '0;
                    n_b     = '0;
                    n_state = KS_MIXRD;
                end
            end
            KS_MIXRD: begin
                o_rd_en = 1'b1;
                n_state = KS_MIXA;
            end
            KS_MIXA: begin
                n_a          = a_new;
                o_wr.en      = 1'b1;
                o_wr.lane_we = r_lane ? 2'b10 : 2'b01;
                o_wr_data    = {a_new, a_new};
                n_state      = KS_MIXB;
            end
            KS_MIXB: begin
                n_b      = b_new;
                n_l[r_j] = b_new;
                n_j      = r_j + 2'd1;
                n_lane   = ~r_lane;
                if (r_lane) begin
                    n_row = row_last ? '0 : r_row + 1'b1;
                end
                if (r_cnt == CNT_W'(MIX_STEPS - 1)) begin
                    o_done  = 1'b1;
                    n_state = KS_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = KS_MIXRD;
                end
            end
            default: begin
                n_state = KS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_CLEAR;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_j    <= n_j;
        r_cnt  <= n_cnt;
        r_a    <= n_a;
        r_b    <= n_b;
        r_v    <= n_v;
        r_l    <= n_l;
    end

    assign o_wr_row   = r_row;
    assign o_clearing = (r_state == KS_CLEAR);

endmodule

// ===== rtl/core/rc6_round.sv =====
// ----------------------------------------------------------------------------
// rc6_round
// Block engine: whitening and one round per issue/apply state pair, fetching one round
// key pair per step from the round key memory.
// ----------------------------------------------------------------------------
module rc6_round
    import rc6_pkg::*;
#(
    parameter int ROWS  = NUM_ROUNDS_DEF + 2,
    parameter int ROW_W = $clog2(ROWS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_blk_cmd         i_cmd,
    input  logic [127:0]     i_block,
    input  logic [63:0]      i_rd_data,
    output logic             o_rd_en,
    output logic [ROW_W-1:0] o_rd_row,
    output logic             o_done,
    output logic [127:0]     o_block
);

    localparam logic [1:0] RD_IDLE  = 2'd0;
    localparam logic [1:0] RD_ISSUE = 2'd1;
    localparam logic [1:0] RD_APPLY = 2'd2;

    logic [1:0]       r_state, n_state;
    logic             r_dec, n_dec;
    logic             r_first, n_first;
    logic [ROW_W-1:0] r_row, n_row;
    logic [31:0]      r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic [31:0]      r_pt, n_pt, r_pu, n_pu;

    logic [31:0] mx_t, mx_u;
    logic [31:0] t, u, k0, k1;
    logic        last;

    assign mx_t = r_dec ? r_a : r_b;
    assign mx_u = r_dec ? r_c : r_d;
    assign t    = rotl32(r_pt, 5'(LG_W));
    assign u    = rotl32(r_pu, 5'(LG_W));
    assign k0   = i_rd_data[31:0];
    assign k1   = i_rd_data[63:32];
    assign last = r_dec ? (r_row == '0) : (r_row == ROW_W'(ROWS - 1));

    always_comb begin
        n_state  = r_state;
        n_dec    = r_dec;
        n_first  = r_first;
        n_row    = r_row;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_pt     = r_pt;
        n_pu     = r_pu;
        o_rd_en  = 1'b0;
        o_done   = 1'b0;
        unique case (r_state)
            RD_IDLE: begin
                if (i_cmd.start) begin
                    n_dec   = i_cmd.decrypt;
                    n_first = 1'b1;
                    n_row   = i_cmd.decrypt ? ROW_W'(ROWS - 1) : '0;
                    n_a     = i_block[31:0];
                    n_b     = i_block[63:32];
                    n_c     = i_block[95:64];
                    n_d     = i_block[127:96];
                    n_state = RD_ISSUE;
                end
            end
            RD_ISSUE: begin
                // fetch the key pair, register the two products
                o_rd_en = 1'b1;
                n_pt    = mx_t * {mx_t[30:0], 1'b1};
                n_pu    = mx_u * {mx_u[30:0], 1'b1};
                n_state = RD_APPLY;
            end
            RD_APPLY: begin
                n_first = 1'b0;
                n_row   = r_dec ? r_row - 1'b1 : r_row + 1'b1;
                n_state = RD_ISSUE;
                if (r_first) begin
                    if (r_dec) begin
                        n_a = r_a - k0;
                        n_c = r_c - k1;
                    end else begin
                        n_b = r_b + k0;
                        n_d = r_d + k1;
                    end
                end else if (last) begin
                    o_done  = 1'b1;
                    n_state = RD_IDLE;
                    if (r_dec) begin
                        n_b = r_b - k0;
                        n_d = r_d - k1;
                    end else begin
                        n_a = r_a + k0;
                        n_c = r_c + k1;
                    end
                end else if (r_dec) begin
                    n_a = rotr32(r_d - k0, u[4:0]) ^ t;
                    n_b = r_a;
                    n_c = rotr32(r_b - k1, t[4:0]) ^ u;
                    n_d = r_c;
                end else begin
                    n_a = r_b;
                    n_b = rotl32(r_c ^ u, t[4:0]) + k1;
                    n_c = r_d;
                    n_d = rotl32(r_a ^ t, u[4:0]) + k0;
                end
            end
            default: begin
                n_state = RD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec   <= n_dec;
        r_first <= n_first;
        r_row   <= n_row;
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_pt    <= n_pt;
        r_pu    <= n_pu;
    end

    assign o_rd_row = r_row;
    assign o_block  = {r_d, r_c, r_b, r_a};

endmodule

// ===== rtl/core/rc6_block_cipher.sv =====
// ----------------------------------------------------------------------------
// rc6_block_cipher
// RC6 block cipher, 32-bit words, NUM_ROUNDS rounds, 128-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_axis_*): one item is an opcode in tuser and four words
//   in tdata. Load key takes the words as key words 0..3, encrypt and decrypt
//   take them as block words A..D, no-op does nothing.
//   Output channel (m_axis_*): exactly one item per input item, in order.
//   Load key and no-op return all-zero words.
// Sequencing:
//   One item at a time; tready drops after an accept and rises again once
//   the result has moved into the output register.
//   Encrypt/decrypt: per key pair, a memory read plus registered multiply,
//   then a round update in the block engine. Load key: one fill write per
//   key pair row, then 6 * (NUM_ROUNDS + 2) mixing steps (read, round key
//   update, key word update). No-op: no engine runs.
// Reset: synchronous, active low. A clearing pass after release zeroes the
//   round key memory; tready stays low during it.
// Stall: a finished result waits in the engine until the output register
//   is free; the output register holds while output tready is low.
// ----------------------------------------------------------------------------
module rc6_block_cipher
    import rc6_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // in_word0, in_word1, in_word2, in_word3
    input  logic [1:0]   s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // out_word0, out_word1, out_word2, out_word3
);

    localparam int RK_ROWS = NUM_ROUNDS + 2;   // one row per key pair
    localparam int ROW_W   = $clog2(RK_ROWS);

    logic     accept;
    logic     ks_start;
    t_blk_cmd blk_cmd;
    logic     nop_acc;

    // round key memory ports
    t_wr_ctl          ks_wr;
    logic [ROW_W-1:0] ks_wr_row;
    logic [63:0]      ks_wr_data;
    logic             ks_rd_en;
    logic [ROW_W-1:0] ks_rd_row;
    logic             blk_rd_en;
    logic [ROW_W-1:0] blk_rd_row;
    logic             ram_rd_en;
    logic [ROW_W-1:0] ram_rd_row;
    logic [63:0]      ram_rd_data;

    logic         ks_clearing;
    logic         ks_done;
    logic         blk_done;
    logic [127:0] blk_block;

    // control: busy from accept until the result is in the output register
    logic         r_busy, n_busy;
    logic         r_pend, n_pend;
    logic         r_zero, n_zero;
    logic         r_out_valid, n_out_valid;
    logic [127:0] r_out_data;
    logic         out_load;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_busy && !ks_clearing;

    // decode the opcode of an accepted item
    always_comb begin
        ks_start = 1'b0;
        blk_cmd  = '0;
        nop_acc  = 1'b0;
        if (accept) begin
            unique case (s_axis_tuser)
                OP_LOAD_KEY: ks_start = 1'b1;
                OP_ENCRYPT:  blk_cmd.start = 1'b1;
                OP_DECRYPT: begin
                    blk_cmd.start   = 1'b1;
                    blk_cmd.decrypt = 1'b1;
                end
                OP_NOP:      nop_acc = 1'b1;
                default:     nop_acc = 1'b1;
            endcase
        end
    end

    // move a finished result out once the output register is free
    assign out_load = r_pend && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_pend      = (r_pend && !out_load) || nop_acc || ks_done || blk_done;
        n_zero      = accept ? !blk_cmd.start : r_zero;
        n_busy      = accept ? 1'b1 : (out_load ? 1'b0 : r_busy);
        n_out_valid = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= n_zero;
        if (out_load) begin
            r_out_data <= r_zero ? '0 : blk_block;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // only one engine runs at a time, so the read port is shared by select
    assign ram_rd_en  = ks_rd_en || blk_rd_en;
    assign ram_rd_row = ks_rd_en ? ks_rd_row : blk_rd_row;

    rc6_rkram #(
        .ROWS  (RK_ROWS),
        .ROW_W (ROW_W)
    ) u_rkram (
        .i_clk     (i_clk),
        .i_wr      (ks_wr),
        .i_wr_row  (ks_wr_row),
        .i_wr_data (ks_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_row  (ram_rd_row),
        .o_rd_data (ram_rd_data)
    );

    rc6_keysched #(
        .ROWS  (RK_ROWS),
        .ROW_W (ROW_W)
    ) u_keysched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ks_start),
        .i_key      (s_axis_tdata),
        .i_rd_data  (ram_rd_data),
        .o_rd_en    (ks_rd_en),
        .o_rd_row   (ks_rd_row),
        .o_wr       (ks_wr),
        .o_wr_row   (ks_wr_row),
        .o_wr_data  (ks_wr_data),
        .o_clearing (ks_clearing),
        .o_done     (ks_done)
    );

    rc6_round #(
        .ROWS  (RK_ROWS),
        .ROW_W (ROW_W)
    ) u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (blk_cmd),
        .i_block   (s_axis_tdata),
        .i_rd_data (ram_rd_data),
        .o_rd_en   (blk_rd_en),
        .o_rd_row  (blk_rd_row),
        .o_done    (blk_done),
        .o_block   (blk_block)
    );

endmodule

// ===== rtl/core/rc6_checker.sv =====
// ----------------------------------------------------------------------------
// rc6_checker
// Port-level checks of the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module rc6_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // a stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // a result never appears in the cycle right after its accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // reset empties the output and blocks input for the clearing pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("output valid or input ready right after reset");

endmodule

bind rc6_block_cipher rc6_checker u_rc6_checker (.*);

// ===== tb/sv/rc6_result_check.sv =====
// ----------------------------------------------------------------------------
// rc6_result_check
// Watches both stream channels of the cipher, predicts one result per
// accepted input item and compares each output item field by field.
// ----------------------------------------------------------------------------
module rc6_result_check
    import rc6_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,    // in_word0, in_word1, in_word2, in_word3
    input  logic [1:0]   i_s_tuser,    // opcode
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,    // out_word0, out_word1, out_word2, out_word3
    output int           o_pending,
    output int           o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RKN = 2 * NUM_ROUNDS + 4;

    logic [31:0]  rk_mem [RKN];
    logic [31:0]  key_mix [4];
    logic [127:0] awaited_results [$];
    int           n_fail;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        n_fail       = 0;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [31:0] amt);
        int sh;
        sh = amt[4:0];
        return (sh == 0) ? x : ((x << sh) | (x >> (32 - sh)));
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input logic [31:0] amt);
        int sh;
        sh = amt[4:0];
        return (sh == 0) ? x : ((x >> sh) | (x << (32 - sh)));
    endfunction

    function automatic logic [31:0] quad_mix(input logic [31:0] x);
        logic [31:0] p;
        p = x * ((x << 1) + 32'd1);
        return rol32(p, LG_W);
    endfunction

    function automatic void clear_keys();
        for (int n = 0; n < RKN; n++) rk_mem[n] = '0;
        for (int n = 0; n < 4; n++) key_mix[n] = '0;
    endfunction

    function automatic void expand_round_keys(input logic [127:0] key);
        logic [31:0] a, b;
        int i, j;
        for (int n = 0; n < 4; n++) key_mix[n] = key[32*n +: 32];
        rk_mem[0] = P32;
        for (int n = 1; n < RKN; n++) rk_mem[n] = rk_mem[n-1] + Q32;
        a = '0;
        b = '0;
        i = 0;
        j = 0;
        for (int n = 0; n < 3 * RKN; n++) begin
            rk_mem[i]  = rol32(rk_mem[i] + a + b, KS_ROT);
            a          = rk_mem[i];
            key_mix[j] = rol32(key_mix[j] + a + b, a + b);
            b          = key_mix[j];
            i          = (i + 1 == RKN) ? 0 : i + 1;
            j          = (j + 1 == 4) ? 0 : j + 1;
        end
    endfunction

    function automatic logic [127:0] encrypt_words(input logic [127:0] blk);
        logic [31:0] a, b, c, d, t, u, s;
        a = blk[31:0];
        b = blk[63:32] + rk_mem[0];
        c = blk[95:64];
        d = blk[127:96] + rk_mem[1];
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
            t = quad_mix(b);
            u = quad_mix(d);
            a = rol32(a ^ t, u) + rk_mem[2*r];
            c = rol32(c ^ u, t) + rk_mem[2*r+1];
            s = a; a = b; b = c; c = d; d = s;
        end
        return {d, c + rk_mem[2*NUM_ROUNDS+3], b, a + rk_mem[2*NUM_ROUNDS+2]};
    endfunction

    function automatic logic [127:0] decrypt_words(input logic [127:0] blk);
        logic [31:0] a, b, c, d, t, u, s;
        a = blk[31:0] - rk_mem[2*NUM_ROUNDS+2];
        b = blk[63:32];
        c = blk[95:64] - rk_mem[2*NUM_ROUNDS+3];
        d = blk[127:96];
        for (int r = NUM_ROUNDS; r >= 1; r--) begin
            s = d; d = c; c = b; b = a; a = s;
            u = quad_mix(d);
            t = quad_mix(b);
            c = ror32(c - rk_mem[2*r+1], t) ^ u;
            a = ror32(a - rk_mem[2*r], u) ^ t;
        end
        return {d - rk_mem[1], c, b - rk_mem[0], a};
    endfunction

    // Result of one input item; load key and no-op give all-zero words.
    function automatic logic [127:0] compute_result(input logic [1:0] op,
                                                    input logic [127:0] words);
        logic [127:0] res;
        res = '0;
        case (op)
            OP_LOAD_KEY: expand_round_keys(words);
            OP_ENCRYPT:  res = encrypt_words(words);
            OP_DECRYPT:  res = decrypt_words(words);
            default:     res = '0;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %08h, expected %08h (t=%0t)", what, got, want, $realtime);
        n_fail++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [127:0] want;
        if (!i_rst_n) begin
            clear_keys();
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected item, word0", i_m_tdata[31:0], '0);
                end else begin
                    want = awaited_results.pop_front();
                    for (int n = 0; n < 4; n++) begin
                        if (i_m_tdata[32*n +: 32] !== want[32*n +: 32])
                            report_mismatch($sformatf("out_word%0d", n),
                                            i_m_tdata[32*n +: 32], want[32*n +: 32]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(compute_result(i_s_tuser, i_s_tdata));
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= n_fail;
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of rc6_block_cipher: directed key loads, blocks and
// no-ops at the word extremes, then random items in three idling phases,
// with a long output hold-off and drains between phases. The result check
// module predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import rc6_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ROUNDS   = NUM_ROUNDS_DEF;
    localparam int PHASE_ITEMS  = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 2 * NUM_ROUNDS + 10;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;    // in_word0, in_word1, in_word2, in_word3
    logic [1:0]   s_axis_tuser;    // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;    // out_word0, out_word1, out_word2, out_word3

    int pending;
    int fail_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;

    rc6_block_cipher #(
        .NUM_ROUNDS(NUM_ROUNDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rc6_result_check #(
        .NUM_ROUNDS(NUM_ROUNDS)
    ) u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Known values on every input from time zero.
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NOP;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_req      = 1'b0;
    end

    // Word with a bias toward the extremes, so carries and rotations by
    // zero and by 31 show up often.
    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(15);
        case (sel)
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h0000_0001 << $urandom_range(31);
            3:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [127:0] pick_block();
        return {pick_word(), pick_word(), pick_word(), pick_word()};
    endfunction

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_item(input logic [1:0] op, input logic [127:0] words);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= words;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        int sel;
        logic [1:0] op;
        sel = $urandom_range(99);
        if (sel < 10)      op = OP_LOAD_KEY;
        else if (sel < 50) op = OP_ENCRYPT;
        else if (sel < 90) op = OP_DECRYPT;
        else               op = OP_NOP;
        send_item(op, pick_block());
    endtask

    task automatic run_directed();
        // blocks with the all-zero round keys left by reset
        send_item(OP_ENCRYPT, '0);
        send_item(OP_ENCRYPT, {4{32'hffff_ffff}});
        send_item(OP_DECRYPT, '0);
        send_item(OP_DECRYPT, {4{32'hffff_ffff}});
        // no-op returns zeros and leaves the keys alone
        send_item(OP_NOP, {4{32'hffff_ffff}});
        send_item(OP_NOP, '0);
        send_item(OP_ENCRYPT, {4{32'h8000_0001}});
        // key extremes
        send_item(OP_LOAD_KEY, '0);
        send_item(OP_ENCRYPT, '0);
        send_item(OP_DECRYPT, {4{32'hffff_ffff}});
        send_item(OP_LOAD_KEY, {4{32'hffff_ffff}});
        send_item(OP_ENCRYPT, {4{32'hffff_ffff}});
        send_item(OP_ENCRYPT, {4{32'haaaa_5555}});
        send_item(OP_DECRYPT, '0);
        send_item(OP_NOP, {4{32'h5555_aaaa}});
        send_item(OP_DECRYPT, {4{32'h5555_aaaa}});
        // byte-counting key, little-endian words
        send_item(OP_LOAD_KEY, {32'h0f0e0d0c, 32'h0b0a0908, 32'h07060504, 32'h03020100});
        send_item(OP_ENCRYPT, {32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110});
        send_item(OP_DECRYPT, {32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110});
        send_item(OP_ENCRYPT, {32'h0000_0001, 32'h8000_0000, 32'h0000_001f, 32'hffff_fffe});
    endtask

    // Output side: random back-pressure, plus one long hold-off on request
    // so the engine and output register fill and the input stalls.
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Count cycles with no accept on either channel; give up at the limit.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 67;
                end
                1: begin
                    tx_idle_pct = 67;
                    rx_idle_pct = 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_req    = 1'b1;
                end
            endcase
            if (ph == 0)
                run_directed();
            repeat (PHASE_ITEMS) send_random();
            drain();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== rc6_block_cipher.f =====
rtl/core/rc6_pkg.sv
rtl/core/rc6_rkram.sv
rtl/core/rc6_keysched.sv
rtl/core/rc6_round.sv
rtl/core/rc6_block_cipher.sv
rtl/core/rc6_checker.sv
tb/sv/rc6_result_check.sv
tb/sv/tb.sv
